// ----- sv/murmur3_32_stream_hash_defines.svh -----
// Assertion macros shared by the murmur3 hash modules.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef MURMUR3_32_STREAM_HASH_DEFINES_SVH
`define MURMUR3_32_STREAM_HASH_DEFINES_SVH
`ifndef SYNTHESIS
`define MM3_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MM3_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define MM3_ASSERT(lbl, prop, msg)
`define MM3_NEVER(lbl, cond, msg)
`endif
`endif

// ----- sv/mm3_pkg.sv -----
// Package for the murmur3 stream hash: constants, state type and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mm3_pkg;
	localparam logic [31:0] C1 = 32'hcc9e2d51;
	localparam logic [31:0] C2 = 32'h1b873593;
	localparam logic [31:0] C3 = 32'he6546b64;
	localparam logic [31:0] F1 = 32'h85ebca6b;
	localparam logic [31:0] F2 = 32'hc2b2ae35;
	localparam logic [2:0]  FULL_BYTES = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MIX,
		S_FIN1,
		S_FIN2,
		S_FIN3
	} state_t;

	typedef struct packed {
		logic load;
		logic mix;
		logic fin1;
		logic fin2;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic fin;
		logic out_free;
	} sts_t;

	function automatic logic [31:0] byte_mask(input logic [2:0] n);
		logic [31:0] m;
		case (n)
			3'd0: m = 32'h0000_0000;
			3'd1: m = 32'h0000_00ff;
			3'd2: m = 32'h0000_ffff;
			3'd3: m = 32'h00ff_ffff;
			default: m = 32'hffff_ffff;
		endcase
		return m;
	endfunction
endpackage
`default_nettype wire

// ----- sv/murmur3_32_stream_hash.sv -----
// MurmurHash3 x86_32 over a stream of little-endian words with a
// configurable seed. A word that does not end the message is registered and
// multiplied by the first constant, then takes the second multiply and the
// accumulator update. A word that ends the message (last set, or fewer than
// four bytes) then also takes the two avalanche multiplies and the output
// load, which waits while the output register stays full. The block takes
// one word at a time; a finished hash waits in its own output register while
// the next message is fed in. Writing the seed restarts the message.
// Depends on mm3_pkg, mm3_ctrl and mm3_datapath.
`timescale 1ns / 1ps
`default_nettype none
module murmur3_32_stream_hash
	import mm3_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      hash
);
	cmd_t cmd;
	sts_t sts;

	mm3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mm3_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last       (last),
		.cmd        (cmd),
		.sts        (sts),
		.hash       (hash),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);
endmodule
`default_nettype wire

// ----- sv/mm3_datapath.sv -----
// Datapath of the murmur3 stream hash: seed, accumulator, length, the
// multiply stages and the output register. Depends on mm3_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "murmur3_32_stream_hash_defines.svh"
module mm3_datapath
	import mm3_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        last,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	output logic [31:0]      hash,
	output logic             out_valid,
	input  wire logic        out_ready
);
	logic [31:0] seed_q;
	logic [31:0] acc_q;
	logic [31:0] len_q;
	logic [31:0] k1_q;
	logic [31:0] f_q;
	logic [31:0] hash_q;
	logic [2:0]  n_q;
	logic        fin_q;
	logic        out_valid_q;

	logic [2:0]  n_eff;
	logic [31:0] word_m;
	logic [31:0] k1_prod;
	logic [31:0] k1_rot;
	logic [31:0] k2;
	logic [31:0] h_x;
	logic [31:0] h_r;
	logic [31:0] h_full;
	logic [31:0] x0;
	logic [31:0] x1;
	logic [31:0] y1;

	assign n_eff   = byte_count[2] ? FULL_BYTES : byte_count;
	assign word_m  = data_word & byte_mask(n_eff);
	assign k1_prod = word_m * C1;
	assign k1_rot  = {k1_q[16:0], k1_q[31:17]};
	assign k2      = k1_rot * C2;
	assign h_x     = acc_q ^ k2;
	assign h_r     = {h_x[18:0], h_x[31:19]};
	assign h_full  = h_r + {h_r[29:0], 2'b00} + C3;
	assign x0      = acc_q ^ len_q;
	assign x1      = x0 ^ {16'd0, x0[31:16]};
	assign y1      = f_q ^ {13'd0, f_q[31:13]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			acc_q  <= '0;
			len_q  <= '0;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
			acc_q  <= cfg_wdata;
			len_q  <= '0;
		end else if (cmd.mix) begin
			acc_q <= (n_q == FULL_BYTES) ? h_full : h_x;
			len_q <= len_q + {29'd0, n_q};
		end else if (cmd.fin1) begin
			acc_q <= seed_q;
			len_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k1_q  <= k1_prod;
			n_q   <= n_eff;
			fin_q <= last || (n_eff != FULL_BYTES);
		end
		if (cmd.fin1) begin
			f_q <= x1 * F1;
		end else if (cmd.fin2) begin
			f_q <= y1 * F2;
		end
		if (cmd.out_load) begin
			hash_q <= f_q ^ {16'd0, f_q[31:16]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.fin      = fin_q;
	assign sts.out_free = !out_valid_q || out_ready;
	assign hash         = hash_q;
	assign out_valid    = out_valid_q;

	`MM3_ASSERT(a_fin_reload, cmd.fin1 |=> (len_q == '0) && (acc_q == seed_q), "accumulator not reloaded after finish")
	`MM3_ASSERT(a_out_hold, out_valid_q && !out_ready |=> out_valid_q, "result word dropped while stalled")
endmodule
`default_nettype wire

// ----- sv/mm3_ctrl.sv -----
// Controller of the murmur3 stream hash: sequences word mixing and the
// final avalanche. Depends on mm3_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "murmur3_32_stream_hash_defines.svh"
module mm3_ctrl
	import mm3_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_MIX;
			end
			S_MIX: begin
				state_d = sts.fin ? S_FIN1 : S_IDLE;
			end
			S_FIN1: state_d = S_FIN2;
			S_FIN2: state_d = S_FIN3;
			S_FIN3: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_MIX:  cmd.mix  = 1'b1;
			S_FIN1: cmd.fin1 = 1'b1;
			S_FIN2: cmd.fin2 = 1'b1;
			S_FIN3: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	`MM3_ASSERT(a_load_mix, cmd.load |=> state_q == S_MIX, "accepted word not mixed next cycle")
	`MM3_NEVER(a_no_overwrite, cmd.out_load && !sts.out_free, "result register overwritten")
	`MM3_ASSERT(a_fin_seq, state_q == S_FIN1 |=> state_q == S_FIN2, "avalanche sequence broken")
endmodule
`default_nettype wire
